[hw/rtl/bltb_pkg.sv]
// ============================================================================
// bltb_pkg
// Shared widths and register codes for the bilinear tile blend unit.
// ============================================================================
package bltb_pkg;

    // register field widths
    localparam int TILE_BITS    = 13;
    localparam int BPP_BITS     = 3;

    // texel and corner layout
    localparam int CHAN_BITS    = 8;
    localparam int PIXEL_BITS   = 32;
    localparam int NUM_CORNERS  = 4;

    // weight, divisor and numerator widths (13 x 13 product, times a texel)
    localparam int WGT_BITS     = 2 * TILE_BITS;
    localparam int NUM_BITS     = WGT_BITS + CHAN_BITS;

    // defaults for the top level parameters
    localparam int DEF_COORD_BITS   = 12;
    localparam int DEF_MAX_CHANNELS = 4;

    // register index codes
    localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BPP         = 2'd2;

    // corner slots
    localparam int CORNER_UL = 0;
    localparam int CORNER_UR = 1;
    localparam int CORNER_DL = 2;
    localparam int CORNER_DR = 3;

    typedef logic [NUM_CORNERS-1:0][CHAN_BITS-1:0]  corner_chan_t;
    typedef logic [NUM_CORNERS-1:0][WGT_BITS-1:0]   corner_wgt_t;
    typedef logic [NUM_CORNERS-1:0][PIXEL_BITS-1:0] corner_pix_t;

endpackage

[hw/rtl/bltb_coord_mod.sv]
// ============================================================================
// bltb_coord_mod
// Pipelined remainder of a coordinate by the tile size, one bit per stage.
// ============================================================================
module bltb_coord_mod #(
    parameter int COORD_BITS = bltb_pkg::DEF_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           adv,
    input  logic [COORD_BITS-1:0]          val_in,
    input  logic [bltb_pkg::TILE_BITS-1:0] divisor,
    output logic [COORD_BITS-1:0]          rem_out
);
    import bltb_pkg::*;

    localparam int WIDE = COORD_BITS + TILE_BITS;

    logic [COORD_BITS-1:0] rem_reg  [0:COORD_BITS-1];
    logic [COORD_BITS-1:0] rem_next [0:COORD_BITS-1];

    // stage s removes divisor shifted by bit COORD_BITS-1-s
    genvar s;
    generate
        for (s = 0; s < COORD_BITS; s++)
        begin : g_stage
            logic [COORD_BITS-1:0] src;
            logic [WIDE-1:0]       shifted;
            logic [WIDE-1:0]       src_wide;

            assign src      = (s == 0) ? val_in : rem_reg[(s == 0) ? 0 : s-1];
            assign src_wide = WIDE'(src);
            assign shifted  = WIDE'(divisor) << (COORD_BITS-1-s);

            always_comb
            begin
                if (src_wide >= shifted)
                begin
                    rem_next[s] = COORD_BITS'(src_wide - shifted);
                end
                else
                begin
                    rem_next[s] = src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s] <= rem_next[s];
                end
            end
        end
    endgenerate

    assign rem_out = rem_reg[COORD_BITS-1];

endmodule

[hw/rtl/bltb_lane.sv]
// ============================================================================
// bltb_lane
// One channel lane: weights times texels, then four pipelined dividers.
// ============================================================================
module bltb_lane (
    input  logic                          clk,
    input  logic                          adv,
    input  bltb_pkg::corner_chan_t        texel,
    input  bltb_pkg::corner_wgt_t         wgt,
    input  logic [bltb_pkg::WGT_BITS-1:0] den,
    output bltb_pkg::corner_chan_t        quot
);
    import bltb_pkg::*;

    localparam int QBITS = CHAN_BITS;
    localparam int WIDE  = NUM_BITS + QBITS;

    logic [NUM_BITS-1:0]  num_reg [0:NUM_CORNERS-1];
    logic [NUM_BITS-1:0]  rem_reg [0:QBITS-1][0:NUM_CORNERS-1];
    logic [QBITS-1:0]     q_reg   [0:QBITS-1][0:NUM_CORNERS-1];

    genvar c, j;
    generate
        for (c = 0; c < NUM_CORNERS; c++)
        begin : g_corner
            // numerator product
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_reg[c] <= NUM_BITS'(texel[c]) * NUM_BITS'(wgt[c]);
                end
            end

            // restoring division, one quotient bit per stage
            for (j = 0; j < QBITS; j++)
            begin : g_div
                logic [NUM_BITS-1:0] src;
                logic [QBITS-1:0]    qsrc;
                logic [WIDE-1:0]     shifted;
                logic [NUM_BITS-1:0] rem_next;
                logic [QBITS-1:0]    q_next;

                assign src     = (j == 0) ? num_reg[c] : rem_reg[(j == 0) ? 0 : j-1][c];
                assign qsrc    = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j-1][c];
                assign shifted = WIDE'(den) << (QBITS-1-j);

                always_comb
                begin
                    if (WIDE'(src) >= shifted)
                    begin
                        rem_next = NUM_BITS'(WIDE'(src) - shifted);
                        q_next   = {qsrc[QBITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = src;
                        q_next   = {qsrc[QBITS-2:0], 1'b0};
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[j][c] <= rem_next;
                        q_reg[j][c]   <= q_next;
                    end
                end
            end

            assign quot[c] = q_reg[QBITS-1][c];
        end
    endgenerate

endmodule

[hw/rtl/bilinear_tile_blend_unit.sv]
// ============================================================================
// bilinear_tile_blend_unit
// Bilinear blend of four corner texels, one output pixel per request.
// ============================================================================
// Takes one request per clock and returns one blended pixel per clock while
// the output is not stalled; each request passes through COORD_BITS stages of the tile
// remainder, one weight stage, one product stage, eight divider stages (one
// quotient bit each) and the output register. Each channel has its own lane
// of four dividers. A stall on the output holds the whole pipeline and the
// input (in_stall) only while a valid result waits. The clamped register
// copies are not held per request, so a write can reach requests in flight.
module bilinear_tile_blend_unit #(
    parameter int COORD_BITS   = bltb_pkg::DEF_COORD_BITS,
    parameter int MAX_CHANNELS = bltb_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [COORD_BITS-1:0]           pos_x,
    input  logic [COORD_BITS-1:0]           pos_y,
    input  logic [bltb_pkg::PIXEL_BITS-1:0] corner_ul,
    input  logic [bltb_pkg::PIXEL_BITS-1:0] corner_ur,
    input  logic [bltb_pkg::PIXEL_BITS-1:0] corner_dl,
    input  logic [bltb_pkg::PIXEL_BITS-1:0] corner_dr,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bltb_pkg::PIXEL_BITS-1:0] blended_pixel
);
    import bltb_pkg::*;

    localparam int LAT = COORD_BITS + 11;

    logic [TILE_BITS-1:0] tile_width_reg;
    logic [TILE_BITS-1:0] tile_height_reg;
    logic [BPP_BITS-1:0]  bpp_reg;
    logic [TILE_BITS-1:0] tw_eff_reg;
    logic [TILE_BITS-1:0] th_eff_reg;
    logic [BPP_BITS-1:0]  nch_reg;
    logic [WGT_BITS-1:0]  den_reg;
    logic                 cfg_wr;
    logic [1:0]           reg_idx;

    logic                 adv;
    logic [LAT-1:0]       vld_reg;
    corner_pix_t          corner_reg [0:COORD_BITS];
    corner_pix_t          corner_in;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [TILE_BITS-1:0] rx;
    logic [TILE_BITS-1:0] ry;
    corner_wgt_t          wgt_reg;
    corner_wgt_t          wgt_next;
    logic [PIXEL_BITS-1:0] blended_reg;
    logic [PIXEL_BITS-1:0] blended_next;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg  <= TILE_BITS'(16);
            tile_height_reg <= TILE_BITS'(16);
            bpp_reg         <= BPP_BITS'(4);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_TILE_WIDTH:  tile_width_reg  <= pwdata[TILE_BITS-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= pwdata[TILE_BITS-1:0];
                REG_BPP:         bpp_reg         <= pwdata[BPP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (reg_idx)
            REG_TILE_WIDTH:  prdata = 32'(tile_width_reg);
            REG_TILE_HEIGHT: prdata = 32'(tile_height_reg);
            REG_BPP:         prdata = 32'(bpp_reg);
            default:         prdata = '0;
        endcase
    end

    // clamped tile sizes, channel count and divisor
    always_ff @(posedge clk)
    begin
        tw_eff_reg <= (tile_width_reg < TILE_BITS'(2)) ? TILE_BITS'(2) : tile_width_reg;
        th_eff_reg <= (tile_height_reg < TILE_BITS'(2)) ? TILE_BITS'(2) : tile_height_reg;
        nch_reg    <= (bpp_reg > BPP_BITS'(MAX_CHANNELS)) ? BPP_BITS'(MAX_CHANNELS) : bpp_reg;
        den_reg    <= WGT_BITS'(tw_eff_reg - TILE_BITS'(1))
                      * WGT_BITS'(th_eff_reg - TILE_BITS'(1));
    end

    // pipeline advance and valid tracking
    assign adv      = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // tile offsets
    bltb_coord_mod #(.COORD_BITS(COORD_BITS)) u_mod_x (
        .clk     (clk),
        .adv     (adv),
        .val_in  (pos_x),
        .divisor (tw_eff_reg),
        .rem_out (cx)
    );

    bltb_coord_mod #(.COORD_BITS(COORD_BITS)) u_mod_y (
        .clk     (clk),
        .adv     (adv),
        .val_in  (pos_y),
        .divisor (th_eff_reg),
        .rem_out (cy)
    );

    // corner texels delayed alongside the remainder stages
    assign corner_in[CORNER_UL] = corner_ul;
    assign corner_in[CORNER_UR] = corner_ur;
    assign corner_in[CORNER_DL] = corner_dl;
    assign corner_in[CORNER_DR] = corner_dr;

    genvar d;
    generate
        for (d = 0; d <= COORD_BITS; d++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    corner_reg[d] <= (d == 0) ? corner_in : corner_reg[(d == 0) ? 0 : d-1];
                end
            end
        end
    endgenerate

    // corner weights
    assign rx = tw_eff_reg - TILE_BITS'(1) - TILE_BITS'(cx);
    assign ry = th_eff_reg - TILE_BITS'(1) - TILE_BITS'(cy);

    always_comb
    begin
        wgt_next[CORNER_UL] = WGT_BITS'(rx) * WGT_BITS'(ry);
        wgt_next[CORNER_UR] = WGT_BITS'(rx) * WGT_BITS'(cy);
        wgt_next[CORNER_DL] = WGT_BITS'(cx) * WGT_BITS'(ry);
        wgt_next[CORNER_DR] = WGT_BITS'(cx) * WGT_BITS'(cy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wgt_reg <= wgt_next;
        end
    end

    // one lane per channel
    corner_chan_t quot [0:MAX_CHANNELS-1];

    genvar k, cc;
    generate
        for (k = 0; k < MAX_CHANNELS; k++)
        begin : g_lane
            corner_chan_t texel;
            for (cc = 0; cc < NUM_CORNERS; cc++)
            begin : g_tex
                assign texel[cc] = corner_reg[COORD_BITS][cc][k*CHAN_BITS +: CHAN_BITS];
            end

            bltb_lane u_lane (
                .clk   (clk),
                .adv   (adv),
                .texel (texel),
                .wgt   (wgt_reg),
                .den   (den_reg),
                .quot  (quot[k])
            );
        end
    endgenerate

    // merge lanes into the output pixel
    always_comb
    begin
        logic [CHAN_BITS+1:0] sum;
        blended_next = '0;
        for (int m = 0; m < MAX_CHANNELS; m++)
        begin
            sum = (CHAN_BITS+2)'(quot[m][CORNER_UL]) + (CHAN_BITS+2)'(quot[m][CORNER_UR])
                + (CHAN_BITS+2)'(quot[m][CORNER_DL]) + (CHAN_BITS+2)'(quot[m][CORNER_DR]);
            if (BPP_BITS'(m) < nch_reg)
            begin
                blended_next[m*CHAN_BITS +: CHAN_BITS] = sum[CHAN_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            blended_reg <= blended_next;
        end
    end

    assign out_valid     = vld_reg[LAT-1];
    assign blended_pixel = blended_reg;

endmodule
